[sv/rti_pkg.sv]
// ---------------------------------------------------------------------------
// rti_pkg
// Shared types and constants of the ray / triangle intersection pipeline.
// ---------------------------------------------------------------------------
package rti_pkg;

  localparam int STATUS_W   = 3;
  localparam int REG_IDX_W  = 3;
  localparam int DIST_W     = 32;
  localparam int DIST_FRAC  = 16;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT      = 3'd0,
    ST_PARALLEL = 3'd1,
    ST_U_OUT    = 3'd2,
    ST_V_OUT    = 3'd3,
    ST_BEHIND   = 3'd4
  } status_t;

  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DIR_X    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_DIR_Y    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_DIR_Z    = 3'd5;

endpackage

[sv/rti_if.sv]
// ---------------------------------------------------------------------------
// rti_if
// Valid/ready channels: triangle words in, intersection result words out.
// ---------------------------------------------------------------------------
interface rti_tri_if #(parameter int W = 24);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] vert0_x;
  logic signed [W-1:0] vert0_y;
  logic signed [W-1:0] vert0_z;
  logic signed [W-1:0] vert1_x;
  logic signed [W-1:0] vert1_y;
  logic signed [W-1:0] vert1_z;
  logic signed [W-1:0] vert2_x;
  logic signed [W-1:0] vert2_y;
  logic signed [W-1:0] vert2_z;

  modport source (output valid, vert0_x, vert0_y, vert0_z, vert1_x, vert1_y, vert1_z,
                  vert2_x, vert2_y, vert2_z, input ready);
  modport sink   (input valid, vert0_x, vert0_y, vert0_z, vert1_x, vert1_y, vert1_z,
                  vert2_x, vert2_y, vert2_z, output ready);
endinterface

interface rti_res_if #(parameter int W = 24);
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic [rti_pkg::STATUS_W-1:0]  status;
  logic [rti_pkg::DIST_W-1:0]    distance;
  logic signed [W-1:0]           point_x;
  logic signed [W-1:0]           point_y;
  logic signed [W-1:0]           point_z;

  modport source (output valid, hit, status, distance, point_x, point_y, point_z,
                  input ready);
  modport sink   (input valid, hit, status, distance, point_x, point_y, point_z,
                  output ready);
endinterface

[sv/ray_triangle_intersect.sv]
// Throughput: one triangle per cycle while the output is not stalled; the
// 32-stage restoring divider for the distance and the split wide multipliers
// of the dot products set the depth. A stalled output holds the whole pipeline
// in place; nothing is dropped. Reset clears all valid bits and loads the ray:
// origin 0, direction (0,-1,0).
// ---------------------------------------------------------------------------
// ray_triangle_intersect
// Exact fixed-point Moller-Trumbore test of one triangle per word against a
// ray held in configuration registers.
// ---------------------------------------------------------------------------
module ray_triangle_intersect #(
  parameter int COORD_WIDTH = 24,
  parameter int FRAC_BITS   = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [rti_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [COORD_WIDTH-1:0]          cfg_data,
  rti_tri_if.sink                         tri_in,
  rti_res_if.source                       res
);
  import rti_pkg::*;

  localparam int W   = COORD_WIDTH;
  localparam int E   = W + 1;            // edge and offset vectors
  localparam int XW  = 2 * E;            // cross product partials and results
  localparam int CW  = XW;
  localparam int L   = E;                // split point of wide dot operands
  localparam int HW  = CW - L;
  localparam int PL  = 2 * E + 1;
  localparam int PH  = E + HW;
  localparam int TW  = E + CW;
  localparam int DW  = 3 * W + 6;        // dot products, with room for u + v
  localparam int RW  = DW + DIST_W;      // divider remainder
  localparam int NST = 8 + DIST_W + 1;   // stages ahead of the output register
  localparam int MW  = W + DIST_W + 1;
  localparam int SW  = MW + 1;
  localparam logic signed [SW-1:0] PMAX = SW'((longint'(1) <<< (W - 1)) - 1);
  localparam logic signed [SW-1:0] PMIN = -PMAX - SW'(1);
  localparam logic [W-1:0] DIR_Y_RESET = W'(-(longint'(1) <<< FRAC_BITS));

  // Ray registers.
  logic signed [W-1:0] org [3];
  logic signed [W-1:0] dir [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      org[0] <= '0;
      org[1] <= '0;
      org[2] <= '0;
      dir[0] <= '0;
      dir[1] <= DIR_Y_RESET;
      dir[2] <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ORIGIN_X: org[0] <= cfg_data;
        REG_ORIGIN_Y: org[1] <= cfg_data;
        REG_ORIGIN_Z: org[2] <= cfg_data;
        REG_DIR_X:    dir[0] <= cfg_data;
        REG_DIR_Y:    dir[1] <= cfg_data;
        REG_DIR_Z:    dir[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline control: every stage moves together.
  logic             adv;
  logic [NST-1:0]   vld;
  logic             out_valid;

  assign adv          = !out_valid || res.ready;
  assign tri_in.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[NST-2:0], tri_in.valid};
      out_valid <= vld[NST-1];
    end
  end

  // Stage 1: edges and origin offset.
  logic signed [W-1:0] v0 [3];
  logic signed [W-1:0] v1 [3];
  logic signed [W-1:0] v2 [3];
  logic signed [E-1:0] s1_e1 [3];
  logic signed [E-1:0] s1_e2 [3];
  logic signed [E-1:0] s1_s  [3];

  always_comb begin
    v0[0] = tri_in.vert0_x; v0[1] = tri_in.vert0_y; v0[2] = tri_in.vert0_z;
    v1[0] = tri_in.vert1_x; v1[1] = tri_in.vert1_y; v1[2] = tri_in.vert1_z;
    v2[0] = tri_in.vert2_x; v2[1] = tri_in.vert2_y; v2[2] = tri_in.vert2_z;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        s1_e1[k] <= E'(v1[k]) - E'(v0[k]);
        s1_e2[k] <= E'(v2[k]) - E'(v0[k]);
        s1_s[k]  <= E'(org[k]) - E'(v0[k]);
      end
    end
  end

  // Stages 2 and 3: h = dir x e2 and q = s x e1.
  logic signed [XW-1:0] s2_hp [3];
  logic signed [XW-1:0] s2_hn [3];
  logic signed [XW-1:0] s2_qp [3];
  logic signed [XW-1:0] s2_qn [3];
  logic signed [E-1:0]  s2_e1 [3];
  logic signed [E-1:0]  s2_e2 [3];
  logic signed [E-1:0]  s2_s  [3];
  logic signed [CW-1:0] s3_h  [3];
  logic signed [CW-1:0] s3_q  [3];
  logic signed [E-1:0]  s3_e1 [3];
  logic signed [E-1:0]  s3_e2 [3];
  logic signed [E-1:0]  s3_s  [3];

  for (genvar k = 0; k < 3; k++) begin : g_cross
    localparam int J = (k + 1) % 3;
    localparam int M = (k + 2) % 3;
    always_ff @(posedge clk) begin
      if (adv) begin
        s2_hp[k] <= XW'(dir[J]) * XW'(s1_e2[M]);
        s2_hn[k] <= XW'(dir[M]) * XW'(s1_e2[J]);
        s2_qp[k] <= XW'(s1_s[J]) * XW'(s1_e1[M]);
        s2_qn[k] <= XW'(s1_s[M]) * XW'(s1_e1[J]);
        s2_e1[k] <= s1_e1[k];
        s2_e2[k] <= s1_e2[k];
        s2_s[k]  <= s1_s[k];
        s3_h[k]  <= s2_hp[k] - s2_hn[k];
        s3_q[k]  <= s2_qp[k] - s2_qn[k];
        s3_e1[k] <= s2_e1[k];
        s3_e2[k] <= s2_e2[k];
        s3_s[k]  <= s2_s[k];
      end
    end
  end

  // Stages 4 to 6: dot products a = e1.h, u = s.h, v = dir.q, t = e2.q.
  // The wide operand is split in two halves so each multiplier stays narrow.
  logic signed [E-1:0]  xop [4][3];
  logic signed [CW-1:0] yop [4][3];
  logic signed [PL-1:0] s4_plo [4][3];
  logic signed [PH-1:0] s4_phi [4][3];
  logic signed [TW-1:0] s5_term [4][3];
  logic signed [DW-1:0] s6_dot [4];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      xop[0][k] = s3_e1[k];   yop[0][k] = s3_h[k];
      xop[1][k] = s3_s[k];    yop[1][k] = s3_h[k];
      xop[2][k] = E'(dir[k]); yop[2][k] = s3_q[k];
      xop[3][k] = s3_e2[k];   yop[3][k] = s3_q[k];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int n = 0; n < 4; n++) begin
        for (int k = 0; k < 3; k++) begin
          s4_plo[n][k]  <= PL'(xop[n][k]) * PL'($signed({1'b0, yop[n][k][L-1:0]}));
          s4_phi[n][k]  <= PH'(xop[n][k]) * PH'($signed(yop[n][k][CW-1:L]));
          s5_term[n][k] <= (TW'(s4_phi[n][k]) <<< L) + TW'(s4_plo[n][k]);
        end
        s6_dot[n] <= DW'(s5_term[n][0]) + DW'(s5_term[n][1]) + DW'(s5_term[n][2]);
      end
    end
  end

  // Stage 7: make the determinant non-negative.
  logic signed [DW-1:0] s7_a, s7_un, s7_vn, s7_tn;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (s6_dot[0] < 0) begin
        s7_a  <= -s6_dot[0];
        s7_un <= -s6_dot[1];
        s7_vn <= -s6_dot[2];
        s7_tn <= -s6_dot[3];
      end else begin
        s7_a  <= s6_dot[0];
        s7_un <= s6_dot[1];
        s7_vn <= s6_dot[2];
        s7_tn <= s6_dot[3];
      end
    end
  end

  // Stage 8 loads the first divider entry: classification, saturation check
  // and divider setup.
  logic signed [DW:0] vsum;
  status_t            st_next;
  logic [RW-1:0]      dv_rem    [DIST_W+1];
  logic [DW-1:0]      dv_den    [DIST_W+1];
  logic [DIST_W-1:0]  dv_q      [DIST_W+1];
  status_t            dv_status [DIST_W+1];
  logic               dv_sat    [DIST_W+1];

  always_comb begin
    vsum = (DW+1)'(s7_un) + (DW+1)'(s7_vn);
    if (s7_a == '0)
      st_next = ST_PARALLEL;
    else if (s7_un < 0 || s7_a < s7_un)
      st_next = ST_U_OUT;
    else if (s7_vn < 0 || (DW+1)'(s7_a) < vsum)
      st_next = ST_V_OUT;
    else if (s7_tn <= 0)
      st_next = ST_BEHIND;
    else
      st_next = ST_HIT;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_status[0] <= st_next;
      dv_sat[0]    <= RW'($unsigned(s7_tn)) >= (RW'($unsigned(s7_a)) << DIST_FRAC);
      dv_rem[0]    <= RW'($unsigned(s7_tn)) << DIST_FRAC;
      dv_den[0]    <= $unsigned(s7_a);
      dv_q[0]      <= '0;
    end
  end

  // Divider: one quotient bit per stage, most significant first.
  for (genvar i = 1; i <= DIST_W; i++) begin : g_div
    localparam int B = DIST_W - i;
    logic [RW-1:0] shifted;
    logic          ge;
    always_comb begin
      shifted = RW'(dv_den[i-1]) << B;
      ge      = dv_rem[i-1] >= shifted;
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem[i]    <= ge ? dv_rem[i-1] - shifted : dv_rem[i-1];
        dv_den[i]    <= dv_den[i-1];
        dv_q[i]      <= {dv_q[i-1][DIST_W-2:0], ge};
        dv_status[i] <= dv_status[i-1];
        dv_sat[i]    <= dv_sat[i-1];
      end
    end
  end

  // Point stage 1: direction times the reported distance.
  logic [DIST_W-1:0]     dist_sel;
  logic signed [MW-1:0]  p1_prod [3];
  logic [DIST_W-1:0]     p1_dist;
  status_t               p1_status;

  assign dist_sel = dv_sat[DIST_W] ? '1 : dv_q[DIST_W];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++)
        p1_prod[k] <= MW'(dir[k]) * MW'($signed({1'b0, dist_sel}));
      p1_dist   <= dist_sel;
      p1_status <= dv_status[DIST_W];
    end
  end

  // Point stage 2: offset from origin, saturate, and drive the output word.
  logic signed [SW-1:0] psum [3];
  logic signed [W-1:0]  psat [3];
  logic                 o_hit;
  status_t              o_status;
  logic [DIST_W-1:0]    o_dist;
  logic signed [W-1:0]  o_pt [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      psum[k] = SW'(org[k]) + SW'(p1_prod[k] >>> DIST_FRAC);
      if (psum[k] > PMAX)
        psat[k] = W'(PMAX);
      else if (psum[k] < PMIN)
        psat[k] = W'(PMIN);
      else
        psat[k] = W'(psum[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_hit    <= p1_status == ST_HIT;
      o_status <= p1_status;
      o_dist   <= (p1_status == ST_HIT) ? p1_dist : '0;
      for (int k = 0; k < 3; k++)
        o_pt[k] <= (p1_status == ST_HIT) ? psat[k] : '0;
    end
  end

  assign res.valid    = out_valid;
  assign res.hit      = o_hit;
  assign res.status   = o_status;
  assign res.distance = o_dist;
  assign res.point_x  = o_pt[0];
  assign res.point_y  = o_pt[1];
  assign res.point_z  = o_pt[2];

`ifndef SYNTH
  // A miss carries no distance and no point.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.hit |-> res.distance == '0 && res.point_x == '0 &&
                              res.point_y == '0 && res.point_z == '0)
    else $error("miss word with nonzero distance or point");

  // A waiting result word holds off new triangle words.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.ready |-> !tri_in.ready)
    else $error("input ready while output stalled");

  // The hit flag agrees with the status code.
  a_hit_status: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> res.hit == (res.status == ST_HIT))
    else $error("hit flag disagrees with status");

  // No result word right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !res.valid)
    else $error("output valid after reset");
`endif

endmodule

[dv/ray_triangle_intersect_tb.sv]
// ---------------------------------------------------------------------------
// ray_triangle_intersect_tb
// Streams triangle words against a series of ray settings and checks every
// result word against an exact fixed-point Moller-Trumbore predictor held in
// a small scoreboard. Both channels idle and stall at random.
// ---------------------------------------------------------------------------
module ray_triangle_intersect_tb;
  import rti_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 24;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd6;
  localparam longint CMAX = (64'sd1 <<< (CW - 1)) - 1;
  localparam longint CMIN = -(64'sd1 <<< (CW - 1));
  localparam int DRAIN_CYCLES = 60;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic signed [CW-1:0] c[9];
  } triangle_t;

  typedef struct {
    logic                 hit;
    status_t              status;
    logic [DIST_W-1:0]    distance;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic signed [CW-1:0] pz;
  } hit_info_t;

  class hit_scoreboard;
    logic signed [CW-1:0] ray[6];
    hit_info_t pending[$];
    int errors;

    function new();
      foreach (ray[i]) ray[i] = '0;
      ray[REG_DIR_Y] = -24'sd256;
      errors = 0;
    endfunction

    function void set_reg(logic [REG_IDX_W-1:0] idx, logic signed [CW-1:0] val);
      if (idx <= REG_DIR_Z) ray[idx] = val;
    endfunction

    function logic signed [CW-1:0] clamp_coord(wide_t p);
      if (p > wide_t'(CMAX)) return CMAX[CW-1:0];
      if (p < wide_t'(CMIN)) return CMIN[CW-1:0];
      return p[CW-1:0];
    endfunction

    // Works out the expected result word for one accepted triangle.
    function void note(triangle_t t);
      wide_t v[9], o[3], d[3], e1[3], e2[3], s[3], h[3], q[3];
      wide_t det, un, vn, tn, quo, dw;
      hit_info_t x;
      foreach (v[i]) v[i] = t.c[i];
      for (int i = 0; i < 3; i++) begin
        o[i] = ray[i];
        d[i] = ray[3 + i];
        e1[i] = v[3 + i] - v[i];
        e2[i] = v[6 + i] - v[i];
        s[i] = o[i] - v[i];
      end
      h[0] = d[1] * e2[2] - d[2] * e2[1];
      h[1] = d[2] * e2[0] - d[0] * e2[2];
      h[2] = d[0] * e2[1] - d[1] * e2[0];
      q[0] = s[1] * e1[2] - s[2] * e1[1];
      q[1] = s[2] * e1[0] - s[0] * e1[2];
      q[2] = s[0] * e1[1] - s[1] * e1[0];
      det = e1[0] * h[0] + e1[1] * h[1] + e1[2] * h[2];
      un = s[0] * h[0] + s[1] * h[1] + s[2] * h[2];
      vn = d[0] * q[0] + d[1] * q[1] + d[2] * q[2];
      tn = e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2];
      if (det < 0) begin
        det = -det; un = -un; vn = -vn; tn = -tn;
      end
      x.distance = '0;
      x.px = '0; x.py = '0; x.pz = '0;
      if (det == 0) x.status = ST_PARALLEL;
      else if (un < 0 || un > det) x.status = ST_U_OUT;
      else if (vn < 0 || un + vn > det) x.status = ST_V_OUT;
      else if (tn <= 0) x.status = ST_BEHIND;
      else x.status = ST_HIT;
      x.hit = (x.status == ST_HIT);
      if (x.hit) begin
        quo = (tn <<< DIST_FRAC) / det;
        x.distance = (quo > wide_t'(64'hFFFF_FFFF)) ? 32'hFFFF_FFFF : quo[31:0];
        dw = wide_t'({96'b0, x.distance});
        x.px = clamp_coord(o[0] + ((d[0] * dw) >>> DIST_FRAC));
        x.py = clamp_coord(o[1] + ((d[1] * dw) >>> DIST_FRAC));
        x.pz = clamp_coord(o[2] + ((d[2] * dw) >>> DIST_FRAC));
      end
      pending = {pending, x};
    endfunction

    function void check(hit_info_t got);
      hit_info_t want;
      if (pending.size() == 0) begin
        $display("%0t: result word with nothing expected, status %0d", $time, got.status);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.hit !== want.hit) begin
        $display("%0t: hit expected %0d actual %0d", $time, want.hit, got.hit);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.distance !== want.distance) begin
        $display("%0t: distance expected %h actual %h", $time, want.distance, got.distance);
        errors++;
      end
      if (got.px !== want.px || got.py !== want.py || got.pz !== want.pz) begin
        $display("%0t: point expected (%0d,%0d,%0d) actual (%0d,%0d,%0d)", $time,
                 want.px, want.py, want.pz, got.px, got.py, got.pz);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_write;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [CW-1:0] cfg_data;
  int send_idle;
  int recv_idle;
  hit_scoreboard sb;

  rti_tri_if #(.W(CW)) tri_in ();
  rti_res_if #(.W(CW)) res ();

  ray_triangle_intersect dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .tri_in(tri_in), .res(res)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  initial begin
    #2ms;
    $display("ray_triangle_intersect_tb: errors");
    $finish;
  end

  always @(posedge clk) begin
    hit_info_t got;
    if (!rst && res.valid && res.ready) begin
      got.hit = res.hit;
      got.status = status_t'(res.status);
      got.distance = res.distance;
      got.px = res.point_x; got.py = res.point_y; got.pz = res.point_z;
      sb.check(got);
    end
    res.ready <= ($urandom_range(99) >= recv_idle);
  end

  function automatic logic signed [CW-1:0] sat(longint x);
    if (x > CMAX) return CMAX[CW-1:0];
    if (x < CMIN) return CMIN[CW-1:0];
    return x[CW-1:0];
  endfunction

  // Any coordinate value, either sign.
  function automatic longint rand_coord();
    logic signed [CW-1:0] r;
    r = CW'($urandom());
    return longint'(r);
  endfunction

  function automatic triangle_t mk(longint a0, longint a1, longint a2, longint b0,
                                   longint b1, longint b2, longint c0, longint c1,
                                   longint c2);
    triangle_t t;
    t.c[0] = sat(a0); t.c[1] = sat(a1); t.c[2] = sat(a2);
    t.c[3] = sat(b0); t.c[4] = sat(b1); t.c[5] = sat(b2);
    t.c[6] = sat(c0); t.c[7] = sat(c1); t.c[8] = sat(c2);
    return t;
  endfunction

  // Mostly triangles placed around a point on the ray line, so that all
  // outcomes come up; the rest are raw noise or flattened triangles.
  function automatic triangle_t random_triangle();
    triangle_t t;
    longint ctr[3];
    longint span;
    int k;
    int pick;
    pick = $urandom_range(99);
    k = $urandom_range(48) - 8;
    span = longint'(1) << $urandom_range(14, 2);
    for (int i = 0; i < 3; i++)
      ctr[i] = longint'(sb.ray[i]) + ((longint'(sb.ray[3 + i]) * k) >>> 2);
    for (int j = 0; j < 9; j++) begin
      if (pick < 15)
        t.c[j] = CW'($urandom());
      else
        t.c[j] = sat(ctr[j % 3] + longint'($urandom_range(2 * span)) - span);
    end
    if (pick >= 15 && pick < 25) begin
      for (int i = 0; i < 3; i++) t.c[6 + i] = t.c[3 + i];
    end
    return t;
  endfunction

  task automatic send(triangle_t t);
    while ($urandom_range(99) < send_idle) begin
      tri_in.valid <= 1'b0;
      @(posedge clk);
    end
    tri_in.valid <= 1'b1;
    tri_in.vert0_x <= t.c[0]; tri_in.vert0_y <= t.c[1]; tri_in.vert0_z <= t.c[2];
    tri_in.vert1_x <= t.c[3]; tri_in.vert1_y <= t.c[4]; tri_in.vert1_z <= t.c[5];
    tri_in.vert2_x <= t.c[6]; tri_in.vert2_y <= t.c[7]; tri_in.vert2_z <= t.c[8];
    @(posedge clk);
    while (!tri_in.ready) @(posedge clk);
    sb.note(t);
  endtask

  task automatic drain();
    tri_in.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_put(logic [REG_IDX_W-1:0] idx, longint val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= sat(val);
    sb.set_reg(idx, sat(val));
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_ray(longint ox, longint oy, longint oz,
                         longint dx, longint dy, longint dz);
    cfg_put(REG_ORIGIN_X, ox);
    cfg_put(REG_ORIGIN_Y, oy);
    cfg_put(REG_ORIGIN_Z, oz);
    cfg_put(REG_DIR_X, dx);
    cfg_put(REG_DIR_Y, dy);
    cfg_put(REG_DIR_Z, dz);
    // A write to an index past the last register must change nothing.
    cfg_put(REG_UNUSED, $urandom());
  endtask

  task automatic run_random(int count);
    for (int n = 0; n < count; n++) send(random_triangle());
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    tri_in.valid = 1'b0;
    {tri_in.vert0_x, tri_in.vert0_y, tri_in.vert0_z} = '0;
    {tri_in.vert1_x, tri_in.vert1_y, tri_in.vert1_z} = '0;
    {tri_in.vert2_x, tri_in.vert2_y, tri_in.vert2_z} = '0;
    res.ready = 1'b0;
    send_idle = 16;
    recv_idle = 53;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words against the reset ray, straight down from the origin.
    send(mk(-256, -2560, -256, 512, -2560, -256, -256, -2560, 512));
    send(mk(-256, -2560, -256, -256, -2560, 512, 512, -2560, -256));
    send(mk(0, -256, 0, 256, -256, 0, 0, -256, 256));
    send(mk(-256, -256, -256, 256, -256, -256, -256, -256, 256));
    send(mk(256, -256, 256, 768, -256, 256, 256, -256, 768));
    send(mk(-512, -256, 256, -256, -256, 256, -512, -256, 512));
    send(mk(-256, -256, -256, 512, -256, -256, -256, -256, 512));
    send(mk(0, 0, 100, 256, -256, 100, 0, -512, 100));
    send(mk(5, 5, 5, 5, 5, 5, 5, 5, 5));
    send(mk(-256, 2560, -256, 512, 2560, -256, -256, 2560, 512));
    send(mk(-256, 0, -256, 512, 0, -256, -256, 0, 512));
    send(mk(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
    send(mk(CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMIN, CMAX));
    send(mk(CMIN, CMIN, CMIN, CMIN, CMIN, CMAX, CMAX, CMIN, CMIN));
    send(mk(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN));
    send(mk(-1, -1, -1, 1, -1, -1, -1, -1, 1));
    run_random(100);
    drain();

    set_ray(longint'($urandom_range(131072)) - 65536,
            longint'($urandom_range(131072)) - 65536,
            longint'($urandom_range(131072)) - 65536,
            longint'($urandom_range(2048)) - 1024,
            longint'($urandom_range(2048)) - 1024,
            longint'($urandom_range(2048)) - 1024);
    run_random(60);
    // Hold the sender off until the pipeline has emptied out.
    tri_in.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    run_random(60);
    drain();

    send_idle = 53;
    recv_idle = 16;
    // Steep ray: a triangle one step below gives a distance under one LSB.
    set_ray(0, 0, 0, 0, CMIN, 0);
    send(mk(-256, -1, -256, 512, -1, -256, -256, -1, 512));
    run_random(110);
    drain();

    // Shallow ray against far triangles saturates the distance.
    set_ray(0, 0, 0, 0, -1, 0);
    send(mk(-256, CMIN, -256, 512, CMIN, -256, -256, CMIN, 512));
    send(mk(-256, -8000000, -256, 512, -8000000, -256, -256, -8000000, 512));
    run_random(110);
    drain();

    send_idle = 0;
    recv_idle = 0;
    set_ray(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN);
    run_random(110);
    drain();

    set_ray(rand_coord(), rand_coord(), rand_coord(),
            rand_coord(), rand_coord(), rand_coord());
    run_random(110);
    drain();

    if (sb.errors == 0)
      $display("ray_triangle_intersect_tb: clean");
    else
      $display("ray_triangle_intersect_tb: errors");
    $finish;
  end

endmodule

[files.f]
sv/rti_pkg.sv
sv/rti_if.sv
sv/ray_triangle_intersect.sv
dv/ray_triangle_intersect_tb.sv
